### rtl/matrix_chain_max_cost_top_macros.svh
// Assertion macros used by the checker file of the matrix chain block.
// Each macro samples on the rising edge of clk and is quiet while rst is high.
`ifndef MATRIX_CHAIN_MAX_COST_TOP_MACROS_SVH
`define MATRIX_CHAIN_MAX_COST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mccm_pkg.sv
package mccm_pkg;

  // Default sizes of the chain storage.
  localparam int MAX_MATRICES_DEF = 8;
  localparam int DIM_BITS_DEF     = 16;

  // Fixed field widths of the words on the ports.
  localparam int DIM_FIELD_W  = 16;
  localparam int IDX_OUT_W    = 3;
  localparam int CHAIN_COST_W = 51;

  // Internal cost arithmetic wraps at this width.
  localparam int COST_W = 64;

  // A chain needs at least this many dimensions (one matrix).
  localparam int MIN_DIMS = 2;

  // Input word: one chain dimension.
  typedef struct packed {
    logic [DIM_FIELD_W-1:0] dimension;
    logic                   last_dimension;
  } mccm_dim_t;

  // Output word: one table entry or the closing total.
  typedef struct packed {
    logic [IDX_OUT_W-1:0]    first_matrix;
    logic [IDX_OUT_W-1:0]    final_matrix;
    logic [CHAIN_COST_W-1:0] chain_cost;
    logic [IDX_OUT_W-1:0]    split_point;
    logic                    is_total;
    logic                    error_flag;
    logic                    last_result;
  } mccm_res_t;

  // Accumulator operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } mccm_acc_op_t;

  // Control word from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic         mul_en;
    mccm_acc_op_t acc_op;
  } mccm_arith_ctrl_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CELL_RDI,
    ST_CELL_RDJ,
    ST_CELL_MUL,
    ST_CELL_PC,
    ST_K_RD,
    ST_K_LEFT,
    ST_K_ADDLO,
    ST_K_ADDR,
    ST_K_ADDHI,
    ST_K_CMP,
    ST_K_WR,
    ST_EMIT_RD,
    ST_EMIT_LD
  } mccm_state_t;

endpackage

### rtl/mccm_arith.sv
module mccm_arith #(
  parameter int DIM_BITS = 16
) (
  input  logic                          clk,
  input  mccm_pkg::mccm_arith_ctrl_t    ctrl,
  input  logic [DIM_BITS-1:0]           mul_a,
  input  logic [DIM_BITS-1:0]           mul_b,
  input  logic [mccm_pkg::COST_W-1:0]   acc_operand,
  output logic [2*DIM_BITS-1:0]         prod,
  output logic [mccm_pkg::COST_W-1:0]   acc
);
  import mccm_pkg::*;

  // Shared multiplier with a registered product.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= (2*DIM_BITS)'(mul_a) * (2*DIM_BITS)'(mul_b);
    end
  end

  // Accumulator: one wide add per cycle, wrapping at the cost width.
  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD: begin
        acc <= acc_operand;
      end
      ACC_ADD: begin
        acc <= acc + acc_operand;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

### rtl/mccm_seq.sv
module mccm_seq #(
  parameter int MAX_MATRICES = 8,
  parameter int DIM_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          dim_valid,
  output logic                          dim_ready,
  input  mccm_pkg::mccm_dim_t           dim_word,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mccm_pkg::mccm_res_t           res_word,
  output mccm_pkg::mccm_arith_ctrl_t    arith_ctrl,
  output logic [DIM_BITS-1:0]           mul_a,
  output logic [DIM_BITS-1:0]           mul_b,
  output logic [mccm_pkg::COST_W-1:0]   acc_operand,
  input  logic [2*DIM_BITS-1:0]         prod,
  input  logic [mccm_pkg::COST_W-1:0]   acc
);
  import mccm_pkg::*;

  localparam int CAP    = MAX_MATRICES + 1;
  localparam int DAW    = $clog2(MAX_MATRICES + 1);
  localparam int TW     = $clog2(MAX_MATRICES);
  localparam int CW     = $clog2(MAX_MATRICES + 2);
  localparam int TDEPTH = 1 << (2 * TW);
  localparam int ENT_W  = COST_W + DAW;

  // Sequencer and index registers.
  mccm_state_t         state, state_next;
  logic [CW-1:0]       count, count_next;
  logic                too_many, too_many_next;
  logic [DAW-1:0]      n, n_next;
  logic [DAW-1:0]      i, i_next;
  logic [DAW-1:0]      j, j_next;
  logic [DAW-1:0]      k, k_next;
  logic                emit_total, emit_total_next;

  // Datapath registers.
  logic [DIM_BITS-1:0]   di, di_next;
  logic [DIM_BITS-1:0]   dk, dk_next;
  logic [2*DIM_BITS-1:0] pc, pc_next;
  logic [COST_W-1:0]     best, best_next;
  logic [DAW-1:0]        best_split, best_split_next;
  mccm_res_t             res_word_next;
  logic                  res_valid_next;

  // Dimension store and cost/split table.
  logic [DIM_BITS-1:0] dim_mem [CAP];
  logic [DIM_BITS-1:0] dim_rd;
  logic                dim_we, dim_re;
  logic [DAW-1:0]      dim_waddr, dim_raddr;
  logic [ENT_W-1:0]    tbl_mem [TDEPTH];
  logic [ENT_W-1:0]    tbl_rd;
  logic                tbl_we, tbl_re;
  logic [2*TW-1:0]     tbl_waddr, tbl_raddr;

  // Helper values.
  logic                accept, out_free, cnt_full, tm_after;
  logic [CW-1:0]       cnt_after;
  logic [DAW-1:0]      k_inc, j_inc, i_inc, i_inc2, n_dec;
  logic [COST_W-1:0]   tbl_cost, cost_left, cost_right;

  assign accept     = dim_valid && dim_ready;
  assign out_free   = !res_valid || res_ready;
  assign dim_ready  = (state == ST_LOAD) && out_free;
  assign cnt_full   = (count == CW'(CAP));
  assign cnt_after  = cnt_full ? count : count + CW'(1);
  assign tm_after   = too_many || cnt_full;
  assign k_inc      = k + DAW'(1);
  assign j_inc      = j + DAW'(1);
  assign i_inc      = i + DAW'(1);
  assign i_inc2     = i + DAW'(2);
  assign n_dec      = n - DAW'(1);
  assign tbl_cost   = tbl_rd[COST_W-1:0];
  assign cost_left  = (k == i) ? '0 : tbl_cost;
  assign cost_right = (k_inc == j) ? '0 : tbl_cost;

  // Dimension store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (dim_we) begin
      dim_mem[dim_waddr] <= DIM_BITS'(dim_word.dimension);
    end
    if (dim_re) begin
      dim_rd <= dim_mem[dim_raddr];
    end
  end

  // Table memory holds {split, cost} per entry, row in the upper index bits.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= {best_split, best};
    end
    if (tbl_re) begin
      tbl_rd <= tbl_mem[tbl_raddr];
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      too_many   <= 1'b0;
      emit_total <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      too_many   <= too_many_next;
      emit_total <= emit_total_next;
      res_valid  <= res_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n          <= n_next;
    i          <= i_next;
    j          <= j_next;
    k          <= k_next;
    di         <= di_next;
    dk         <= dk_next;
    pc         <= pc_next;
    best       <= best_next;
    best_split <= best_split_next;
    res_word   <= res_word_next;
  end

  // Next state, register updates and unit control.
  always_comb begin
    state_next      = state;
    count_next      = count;
    too_many_next   = too_many;
    n_next          = n;
    i_next          = i;
    j_next          = j;
    k_next          = k;
    emit_total_next = emit_total;
    di_next         = di;
    dk_next         = dk;
    pc_next         = pc;
    best_next       = best;
    best_split_next = best_split;
    res_word_next   = res_word;
    res_valid_next  = res_valid && !res_ready;
    dim_we          = 1'b0;
    dim_re          = 1'b0;
    dim_waddr       = count[DAW-1:0];
    dim_raddr       = i;
    tbl_we          = 1'b0;
    tbl_re          = 1'b0;
    tbl_waddr       = {i[TW-1:0], j[TW-1:0]};
    tbl_raddr       = {i[TW-1:0], k[TW-1:0]};
    arith_ctrl      = '{mul_en: 1'b0, acc_op: ACC_HOLD};
    mul_a           = di;
    mul_b           = dim_rd;
    acc_operand     = cost_left;

    case (state)
      // Take dimension words; the last one starts the run or reports an error.
      ST_LOAD: begin
        if (accept) begin
          dim_we = !cnt_full;
          if (dim_word.last_dimension) begin
            count_next    = '0;
            too_many_next = 1'b0;
            if (tm_after || (cnt_after < CW'(MIN_DIMS))) begin
              res_word_next  = '{first_matrix: '0, final_matrix: '0, chain_cost: '0,
                                 split_point: '0, is_total: 1'b1, error_flag: 1'b1,
                                 last_result: 1'b1};
              res_valid_next = 1'b1;
            end else begin
              n_next = DAW'(cnt_after - CW'(1));
              if (cnt_after == CW'(MIN_DIMS)) begin
                emit_total_next = 1'b1;
                state_next      = ST_EMIT_RD;
              end else begin
                i_next     = '0;
                j_next     = DAW'(1);
                state_next = ST_CELL_RDI;
              end
            end
          end else begin
            count_next    = cnt_after;
            too_many_next = tm_after;
          end
        end
      end

      // Per table entry: fetch the outer dimensions and form their product.
      ST_CELL_RDI: begin
        dim_re     = 1'b1;
        dim_raddr  = i;
        state_next = ST_CELL_RDJ;
      end
      ST_CELL_RDJ: begin
        di_next    = dim_rd;
        dim_re     = 1'b1;
        dim_raddr  = j_inc;
        state_next = ST_CELL_MUL;
      end
      ST_CELL_MUL: begin
        arith_ctrl.mul_en = 1'b1;
        mul_a             = di;
        mul_b             = dim_rd;
        k_next            = i;
        state_next        = ST_CELL_PC;
      end
      ST_CELL_PC: begin
        pc_next    = prod;
        state_next = ST_K_RD;
      end

      // Per split: fetch the middle dimension and the left sub-chain cost.
      ST_K_RD: begin
        dim_re     = 1'b1;
        dim_raddr  = k_inc;
        tbl_re     = 1'b1;
        tbl_raddr  = {i[TW-1:0], k[TW-1:0]};
        state_next = ST_K_LEFT;
      end
      ST_K_LEFT: begin
        dk_next           = dim_rd;
        arith_ctrl.mul_en = 1'b1;
        mul_a             = pc[DIM_BITS-1:0];
        mul_b             = dim_rd;
        arith_ctrl.acc_op = ACC_LOAD;
        acc_operand       = cost_left;
        tbl_re            = 1'b1;
        tbl_raddr         = {k_inc[TW-1:0], j[TW-1:0]};
        state_next        = ST_K_ADDLO;
      end
      ST_K_ADDLO: begin
        arith_ctrl.acc_op = ACC_ADD;
        acc_operand       = COST_W'(prod);
        arith_ctrl.mul_en = 1'b1;
        mul_a             = pc[2*DIM_BITS-1:DIM_BITS];
        mul_b             = dk;
        state_next        = ST_K_ADDR;
      end
      ST_K_ADDR: begin
        arith_ctrl.acc_op = ACC_ADD;
        acc_operand       = cost_right;
        state_next        = ST_K_ADDHI;
      end
      ST_K_ADDHI: begin
        arith_ctrl.acc_op = ACC_ADD;
        acc_operand       = COST_W'(prod) << DIM_BITS;
        state_next        = ST_K_CMP;
      end

      // Keep the largest cost; the first split seeds it, ties keep the earlier one.
      ST_K_CMP: begin
        if ((k == i) || (acc > best)) begin
          best_next       = acc;
          best_split_next = k_inc;
        end
        k_next     = k_inc;
        state_next = (k_inc == j) ? ST_K_WR : ST_K_RD;
      end

      // Store the entry and move to the next cell, diagonal by diagonal.
      ST_K_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {i[TW-1:0], j[TW-1:0]};
        if (j_inc == n) begin
          if (i == '0) begin
            i_next          = '0;
            j_next          = DAW'(1);
            emit_total_next = 1'b0;
            state_next      = ST_EMIT_RD;
          end else begin
            i_next     = '0;
            j_next     = DAW'(j - i + DAW'(1));
            state_next = ST_CELL_RDI;
          end
        end else begin
          i_next     = i_inc;
          j_next     = j_inc;
          state_next = ST_CELL_RDI;
        end
      end

      // Read out the upper triangle row by row, then the total.
      ST_EMIT_RD: begin
        tbl_re     = 1'b1;
        tbl_raddr  = emit_total ? {{TW{1'b0}}, n_dec[TW-1:0]} : {i[TW-1:0], j[TW-1:0]};
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          res_valid_next = 1'b1;
          if (emit_total) begin
            res_word_next.first_matrix = '0;
            res_word_next.final_matrix = IDX_OUT_W'(n_dec);
            res_word_next.chain_cost   = (n == DAW'(1)) ? '0 : tbl_rd[CHAIN_COST_W-1:0];
            res_word_next.split_point  = '0;
            res_word_next.is_total     = 1'b1;
            res_word_next.error_flag   = 1'b0;
            res_word_next.last_result  = 1'b1;
            emit_total_next            = 1'b0;
            state_next                 = ST_LOAD;
          end else begin
            res_word_next.first_matrix = IDX_OUT_W'(i);
            res_word_next.final_matrix = IDX_OUT_W'(j);
            res_word_next.chain_cost   = tbl_rd[CHAIN_COST_W-1:0];
            res_word_next.split_point  = IDX_OUT_W'(tbl_rd[COST_W +: DAW]);
            res_word_next.is_total     = 1'b0;
            res_word_next.error_flag   = 1'b0;
            res_word_next.last_result  = 1'b0;
            if (j_inc == n) begin
              if (i_inc2 < n) begin
                i_next = i_inc;
                j_next = i_inc2;
              end else begin
                emit_total_next = 1'b1;
              end
            end else begin
              j_next = j_inc;
            end
            state_next = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

### rtl/matrix_chain_max_cost_top.sv
// Maximum-cost matrix chain engine. Dimension words arrive one per cycle on the
// dim channel while it is ready (rows of the first matrix, then the columns of
// each matrix); the word marked last_dimension starts the run. The block fills
// the interval tables for all sub-chains, keeping the largest multiplication
// count and the smallest split on ties, then sends every upper-triangle entry in
// row-major order followed by one total word with is_total and last_result set.
// Fewer than two dimensions, or more than MAX_MATRICES+1, give a single error
// word. Every split point is worked through the one shared multiplier and
// accumulator. The dim channel is ready only while loading and while no result
// word is stalled, so not during the run; costs are computed at 64 bits and
// reported in the 51-bit chain_cost field.
module matrix_chain_max_cost_top #(
  parameter int MAX_MATRICES = mccm_pkg::MAX_MATRICES_DEF,
  parameter int DIM_BITS     = mccm_pkg::DIM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 dim_valid,
  output logic                 dim_ready,
  input  mccm_pkg::mccm_dim_t  dim_word,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mccm_pkg::mccm_res_t  res_word
);
  import mccm_pkg::*;

  mccm_arith_ctrl_t      arith_ctrl;
  logic [DIM_BITS-1:0]   mul_a;
  logic [DIM_BITS-1:0]   mul_b;
  logic [COST_W-1:0]     acc_operand;
  logic [2*DIM_BITS-1:0] prod;
  logic [COST_W-1:0]     acc;

  // Sequencer with the dimension store, tables and output register.
  mccm_seq #(
    .MAX_MATRICES (MAX_MATRICES),
    .DIM_BITS     (DIM_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .dim_valid   (dim_valid),
    .dim_ready   (dim_ready),
    .dim_word    (dim_word),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_word    (res_word),
    .arith_ctrl  (arith_ctrl),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .acc_operand (acc_operand),
    .prod        (prod),
    .acc         (acc)
  );

  // Shared multiplier and accumulator.
  mccm_arith #(
    .DIM_BITS (DIM_BITS)
  ) u_arith (
    .clk         (clk),
    .ctrl        (arith_ctrl),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .acc_operand (acc_operand),
    .prod        (prod),
    .acc         (acc)
  );

endmodule

### rtl/mccm_checker.sv
`include "matrix_chain_max_cost_top_macros.svh"

module mccm_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 dim_valid,
  input logic                 dim_ready,
  input mccm_pkg::mccm_dim_t  dim_word,
  input logic                 res_valid,
  input logic                 res_ready,
  input mccm_pkg::mccm_res_t  res_word
);
  import mccm_pkg::*;

  logic dim_last_seen;
  logic res_stall;
  logic err_seen, err_shape_ok;
  logic flags_agree;
  logic total_seen, total_shape_ok;

  // An accepted last word starts a run.
  assign dim_last_seen = dim_valid && dim_ready && dim_word.last_dimension;

  // Conditions on the result word.
  assign res_stall      = res_valid && !res_ready;
  assign err_seen       = res_valid && res_word.error_flag;
  assign err_shape_ok   = res_word.is_total && res_word.last_result &&
                          (res_word.chain_cost == '0);
  assign flags_agree    = !res_valid || (res_word.is_total == res_word.last_result);
  assign total_seen     = res_valid && res_word.is_total && !res_word.error_flag;
  assign total_shape_ok = (res_word.split_point == '0) && (res_word.first_matrix == '0);

  // A stalled result word holds.
  `MCCM_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_word), "result word changed")

  // An error word is the whole run: total, last and zero cost.
  `MCCM_ASSERT_NOW(a_err_shape, err_seen, err_shape_ok, "malformed error word")

  // Only the total closes a run.
  `MCCM_ASSERT_NOW(a_total_last, res_valid || dim_last_seen, flags_agree, "flags disagree")

  // A good total starts at the first matrix and carries no split.
  `MCCM_ASSERT_NOW(a_total_shape, total_seen, total_shape_ok, "malformed total word")

endmodule

bind matrix_chain_max_cost_top mccm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .dim_valid (dim_valid),
  .dim_ready (dim_ready),
  .dim_word  (dim_word),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_word  (res_word)
);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mccm_pkg::*;

  localparam int MAX_DIMS   = MAX_MATRICES_DEF + 1;
  localparam int RAND_ITEMS = 105;

  // One row of the directed stimulus: a dimension word and, where it can be
  // read off at a glance, the single result word it must produce.
  typedef struct {
    mccm_dim_t word;
    bit        typed;
    mccm_res_t want;
  } dim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      dim_valid = 1'b0;
  logic      dim_ready;
  mccm_dim_t dim_word = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  mccm_res_t res_word;

  // Chain predictor state.
  logic [63:0] stored_dims [MAX_DIMS];
  int          dims_held = 0;
  bit          chain_overflow = 1'b0;
  logic [63:0] best_cost [MAX_MATRICES_DEF][MAX_MATRICES_DEF];
  logic [2:0]  best_cut  [MAX_MATRICES_DEF][MAX_MATRICES_DEF];

  mccm_res_t fresh_results [$];
  mccm_res_t results_due [$];
  dim_row_t  directed_rows [$];

  int mismatch_count = 0;
  int chains_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  matrix_chain_max_cost_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .dim_valid (dim_valid),
    .dim_ready (dim_ready),
    .dim_word  (dim_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  // Free-running clock, 2 ns period.
  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic mccm_res_t make_word(input logic [2:0] first_idx,
                                          input logic [2:0] last_idx,
                                          input logic [63:0] cost,
                                          input logic [2:0] cut,
                                          input logic total, input logic err,
                                          input logic closing);
    mccm_res_t w;
    w.first_matrix = first_idx;
    w.final_matrix = last_idx;
    w.chain_cost   = cost[CHAIN_COST_W-1:0];
    w.split_point  = cut;
    w.is_total     = total;
    w.error_flag   = err;
    w.last_result  = closing;
    return w;
  endfunction

  function automatic dim_row_t dir_row(input logic [15:0] dim, input logic last,
                                       input bit typed, input mccm_res_t want);
    dim_row_t r;
    r.word.dimension      = dim;
    r.word.last_dimension = last;
    r.typed               = typed;
    r.want                = want;
    return r;
  endfunction

  // Mix of extremes, tiny values (to force ties) and full-range values.
  function automatic logic [15:0] random_dimension();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 4));
      default: return 16'($urandom());
    endcase
  endfunction

  // Store one dimension word; on the last marker, fill the interval tables
  // for the largest split cost and leave the result words in fresh_results.
  task automatic absorb_dimension(input mccm_dim_t w);
    int n, span, lo, hi, cut;
    logic [63:0] trial;
    fresh_results.delete();
    if (dims_held < MAX_DIMS) begin
      stored_dims[dims_held] = 64'(w.dimension);
      dims_held++;
    end else begin
      chain_overflow = 1'b1;
    end
    if (!w.last_dimension) return;

    if (chain_overflow || dims_held < MIN_DIMS) begin
      fresh_results.push_back(make_word('0, '0, '0, '0, 1'b1, 1'b1, 1'b1));
    end else begin
      n = dims_held - 1;
      for (lo = 0; lo < n; lo++) best_cost[lo][lo] = '0;
      for (span = 2; span <= n; span++) begin
        for (lo = 0; lo + span <= n; lo++) begin
          hi = lo + span - 1;
          for (cut = lo; cut < hi; cut++) begin
            trial = best_cost[lo][cut] + best_cost[cut+1][hi]
                    + stored_dims[lo] * stored_dims[cut+1] * stored_dims[hi+1];
            // Strictly greater keeps the smallest split on a tie.
            if (cut == lo || trial > best_cost[lo][hi]) begin
              best_cost[lo][hi] = trial;
              best_cut[lo][hi]  = 3'(cut + 1);
            end
          end
        end
      end
      for (lo = 0; lo < n; lo++) begin
        for (hi = lo + 1; hi < n; hi++) begin
          fresh_results.push_back(make_word(3'(lo), 3'(hi), best_cost[lo][hi],
                                            best_cut[lo][hi], 1'b0, 1'b0, 1'b0));
        end
      end
      fresh_results.push_back(make_word('0, 3'(n - 1), best_cost[0][n-1], '0,
                                        1'b1, 1'b0, 1'b1));
    end
    dims_held      = 0;
    chain_overflow = 1'b0;
  endtask

  // Idling phases rotate with each chain: none, sender, receiver, both light.
  task automatic pick_phase();
    case (chains_sent % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  // Offer one dimension word, with random gaps before it, and wait for it
  // to be taken. Returns with the predicted words in fresh_results.
  task automatic send_word(input mccm_dim_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      dim_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    dim_valid <= 1'b1;
    dim_word  <= w;
    @(posedge clk);
    while (!dim_ready) @(posedge clk);
    absorb_dimension(w);
    if (w.last_dimension) begin
      chains_sent++;
      pick_phase();
    end
  endtask

  task automatic hold_until_drained();
    dim_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("%0t: result word %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  task automatic compare_result(input mccm_res_t got);
    mccm_res_t want;
    if (results_due.size() == 0) begin
      flag_mismatch("with none outstanding", 64'(got.chain_cost), '0);
      return;
    end
    want = results_due.pop_front();
    if (got.first_matrix !== want.first_matrix)
      flag_mismatch("first_matrix", 64'(got.first_matrix), 64'(want.first_matrix));
    if (got.final_matrix !== want.final_matrix)
      flag_mismatch("final_matrix", 64'(got.final_matrix), 64'(want.final_matrix));
    if (got.chain_cost !== want.chain_cost)
      flag_mismatch("chain_cost", 64'(got.chain_cost), 64'(want.chain_cost));
    if (got.split_point !== want.split_point)
      flag_mismatch("split_point", 64'(got.split_point), 64'(want.split_point));
    if (got.is_total !== want.is_total)
      flag_mismatch("is_total", 64'(got.is_total), 64'(want.is_total));
    if (got.error_flag !== want.error_flag)
      flag_mismatch("error_flag", 64'(got.error_flag), 64'(want.error_flag));
    if (got.last_result !== want.last_result)
      flag_mismatch("last_result", 64'(got.last_result), 64'(want.last_result));
  endtask

  // Result side: check each word taken, then stall at random.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) compare_result(res_word);
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus: directed rows, then random chains, then drain and verdict.
  initial begin
    mccm_res_t error_word, single_total;
    mccm_dim_t w;
    int i, len, stored, pick;

    error_word   = make_word('0, '0, '0, '0, 1'b1, 1'b1, 1'b1);
    single_total = make_word('0, '0, '0, '0, 1'b1, 1'b0, 1'b1);

    // Too few dimensions straight after reset.
    directed_rows.push_back(dir_row(16'd5, 1'b1, 1'b1, error_word));
    // One matrix at full size: no entries, total of zero.
    directed_rows.push_back(dir_row(16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(dir_row(16'hFFFF, 1'b1, 1'b1, single_total));
    // Zero dimension in a two-matrix chain.
    directed_rows.push_back(dir_row(16'h0000, 1'b0, 1'b0, '0));
    directed_rows.push_back(dir_row(16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(dir_row(16'h0001, 1'b1, 1'b0, '0));
    // Longest chain, all dimensions at the maximum: widest costs, all ties.
    for (i = 0; i < MAX_DIMS; i++)
      directed_rows.push_back(dir_row(16'hFFFF, i == MAX_DIMS - 1, 1'b0, '0));
    // One dimension too many.
    for (i = 0; i <= MAX_DIMS; i++)
      directed_rows.push_back(dir_row(i[0] ? 16'h5555 : 16'hAAAA, i == MAX_DIMS,
                                      i == MAX_DIMS, error_word));

    pick_phase();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].word);
      if (directed_rows[r].typed) results_due.push_back(directed_rows[r].want);
      else foreach (fresh_results[k]) results_due.push_back(fresh_results[k]);
    end
    hold_until_drained();

    // Random chains: mostly well formed, some too short or too long.
    stored = 0;
    while (stored < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) len = 1;
      else if (pick < 14) len = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 3);
      else if (pick < 70) len = $urandom_range(2, 5);
      else len = $urandom_range(6, MAX_DIMS);
      for (i = 0; i < len; i++) begin
        w.dimension      = random_dimension();
        w.last_dimension = (i == len - 1);
        send_word(w);
        foreach (fresh_results[k]) results_due.push_back(fresh_results[k]);
        if (i < MAX_DIMS) stored++;
      end
      if (chains_sent == 12) hold_until_drained();
    end

    dim_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### matrix_chain_max_cost_top.f
+incdir+rtl
rtl/mccm_pkg.sv
rtl/mccm_arith.sv
rtl/mccm_seq.sv
rtl/matrix_chain_max_cost_top.sv
rtl/mccm_checker.sv
verif/testbench.sv
